FILE: rtl/dss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dss_pkg: shared types and codes for the delimited segment splitter
// Item layouts of both channels, result kinds, request kinds and register
// indexes of the configuration port.
// ----------------------------------------------------------------------------
package dss_pkg;

    // Default depth of the byte window, equal to the longest delimiter
    localparam int MAX_DELIM_DEF = 8;

    // Register and field widths
    localparam int LEN_W     = 4;
    localparam int DELIM_W   = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    // Request kinds
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_SEG_END = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Segment types
    localparam logic SEG_TEXT = 1'b0;
    localparam logic SEG_LINK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LEN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_BYTES = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic       segment_type;
        logic       last_of_run;
    } t_out_item;

endpackage
`default_nettype wire

FILE: rtl/delimited_segment_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delimited_segment_splitter: byte stream to text and link segments
// Finds configured opening and closing delimiters in a byte stream and emits
// the stream as data items, segment-end markers and an end-of-stream error.
// ----------------------------------------------------------------------------
// Each input item is one byte or an end-of-input mark. Bytes that may still
// start the active delimiter wait in a window of P_MAX_DELIM entries; a full
// match emits a segment end and flips text/link mode, a mismatch releases the
// front byte as data. The scan engine performs one scan step per cycle unless
// the output stalls, and each step yields at most one result. An item causes
// at most P_MAX_DELIM results, and no new item is taken until the previous
// one is fully scanned; a byte causing zero or one result is taken every
// cycle while the output does not stall. End of input releases the held bytes
// ahead of any final marker. The first result passes the input and output
// registers. The item carrying last_of_run closes the results of one input
// item. Delimiter registers may be rewritten between items; the held window
// is rescanned against the new delimiter when the next item arrives.
// ----------------------------------------------------------------------------
module delimited_segment_splitter #(
    parameter int P_MAX_DELIM = dss_pkg::MAX_DELIM_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration write port
    input  wire                              i_cfg_we,
    input  wire [dss_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [dss_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire dss_pkg::t_in_item           i_in_item,
    // output channel
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output dss_pkg::t_out_item               o_out_item
);

    localparam int CW = $clog2(P_MAX_DELIM + 1);

    typedef logic [P_MAX_DELIM-1:0][7:0] t_win;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // Clamp a register length into 1..P_MAX_DELIM.
    function automatic logic [CW-1:0] f_eff_len(input logic [dss_pkg::LEN_W-1:0] len);
        logic [CW-1:0] r;
        if (len == '0) begin
            r = CW'(1);
        end else if (len > dss_pkg::LEN_W'(P_MAX_DELIM)) begin
            r = CW'(P_MAX_DELIM);
        end else begin
            r = CW'(len);
        end
        return r;
    endfunction

    // Held bytes agree with the delimiter over min(cnt, len) positions.
    function automatic logic f_match(input t_win win, input logic [CW-1:0] cnt,
                                     input logic [dss_pkg::DELIM_W-1:0] bytes,
                                     input logic [CW-1:0] len);
        logic m;
        m = 1'b1;
        for (int i = 0; i < P_MAX_DELIM; i++) begin
            if (CW'(i) < cnt && CW'(i) < len && win[i] != bytes[8*i +: 8]) begin
                m = 1'b0;
            end
        end
        return m;
    endfunction

    // Drop k bytes from the window front.
    function automatic t_win f_drop(input t_win win, input logic [CW-1:0] k);
        t_win r;
        r = win;
        for (int i = 0; i < P_MAX_DELIM; i++) begin
            for (int j = 1; j <= P_MAX_DELIM; j++) begin
                if (i + j < P_MAX_DELIM) begin
                    if (k == CW'(j)) begin
                        r[i] = win[i + j];
                    end
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [dss_pkg::LEN_W-1:0]   r_open_len, r_close_len;
    logic [dss_pkg::DELIM_W-1:0] r_open_bytes, r_close_bytes;

    logic                r_in_valid, n_in_valid;
    dss_pkg::t_in_item   r_in_item;

    t_win                r_win, n_win;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_link, n_link;
    logic                r_ne, n_ne;
    logic                r_flush, n_flush;
    logic                r_busy, n_busy;

    logic                r_out_valid;
    dss_pkg::t_out_item  r_out_item;

    // ------------------------------------------------------------------
    // Scan step
    // ------------------------------------------------------------------
    logic                        can_emit, take, go, in_acc;
    t_win                        e_win;
    logic [CW-1:0]               e_cnt;
    logic                        e_flush;
    logic [dss_pkg::DELIM_W-1:0] sel_bytes, nx_bytes;
    logic [CW-1:0]               sel_len, nx_len;
    logic                        cur_match, nx_match;
    logic                        res_valid;
    dss_pkg::t_out_item          res;

    always_comb begin
        // output register frees up this cycle or is empty
        can_emit = !r_out_valid || !i_out_stall;
        // engine takes a new item only once the previous one is fully scanned
        take     = r_in_valid && !r_busy && can_emit;
        go       = can_emit && (r_busy || r_in_valid);

        in_acc     = i_in_valid && !o_in_stall;
        o_in_stall = r_in_valid && !take;
        n_in_valid = in_acc ? 1'b1 : (take ? 1'b0 : r_in_valid);

        // working copy: append the new byte or enter flush
        e_win   = r_win;
        e_cnt   = r_cnt;
        e_flush = r_flush;
        if (take) begin
            if (r_in_item.req_type == dss_pkg::REQ_DATA) begin
                if (r_cnt < CW'(P_MAX_DELIM)) begin
                    for (int i = 0; i < P_MAX_DELIM; i++) begin
                        if (CW'(i) == r_cnt) begin
                            e_win[i] = r_in_item.in_byte;
                        end
                    end
                    e_cnt = r_cnt + CW'(1);
                end
            end else begin
                e_flush = 1'b1;
            end
        end

        sel_bytes = r_link ? r_close_bytes : r_open_bytes;
        sel_len   = f_eff_len(r_link ? r_close_len : r_open_len);
        cur_match = f_match(e_win, e_cnt, sel_bytes, sel_len);

        n_win     = r_win;
        n_cnt     = r_cnt;
        n_link    = r_link;
        n_ne      = r_ne;
        n_flush   = r_flush;
        n_busy    = r_busy;
        res_valid = 1'b0;
        res       = '0;

        nx_bytes  = '0;
        nx_len    = '0;
        nx_match  = 1'b0;

        if (go) begin
            res.segment_type = r_link;
            if (e_flush) begin
                if (e_cnt != '0) begin
                    // release held bytes; a final marker always follows
                    res_valid     = 1'b1;
                    res.out_kind  = dss_pkg::KIND_DATA;
                    res.out_byte  = e_win[0];
                    n_win         = f_drop(e_win, CW'(1));
                    n_cnt         = e_cnt - CW'(1);
                    n_ne          = 1'b1;
                    n_flush       = 1'b1;
                    n_busy        = 1'b1;
                end else begin
                    // close the stream and return to text mode
                    res_valid       = r_link || r_ne;
                    res.out_kind    = r_link ? dss_pkg::KIND_ERROR : dss_pkg::KIND_SEG_END;
                    res.last_of_run = 1'b1;
                    n_win           = e_win;
                    n_cnt           = '0;
                    n_link          = 1'b0;
                    n_ne            = 1'b0;
                    n_flush         = 1'b0;
                    n_busy          = 1'b0;
                end
            end else begin
                n_win  = e_win;
                n_cnt  = e_cnt;
                n_busy = 1'b0;
                if (cur_match && e_cnt >= sel_len) begin
                    // full delimiter at the front: end segment, flip mode
                    res_valid    = 1'b1;
                    res.out_kind = dss_pkg::KIND_SEG_END;
                    n_win        = f_drop(e_win, sel_len);
                    n_cnt        = e_cnt - sel_len;
                    n_link       = !r_link;
                    n_ne         = 1'b0;
                end else if (!cur_match) begin
                    // front byte cannot start a delimiter: release it
                    res_valid    = 1'b1;
                    res.out_kind = dss_pkg::KIND_DATA;
                    res.out_byte = e_win[0];
                    n_win        = f_drop(e_win, CW'(1));
                    n_cnt        = e_cnt - CW'(1);
                    n_ne         = 1'b1;
                end
                // look ahead: does the remaining window need another step?
                if (res_valid) begin
                    nx_bytes        = n_link ? r_close_bytes : r_open_bytes;
                    nx_len          = f_eff_len(n_link ? r_close_len : r_open_len);
                    nx_match        = f_match(n_win, n_cnt, nx_bytes, nx_len);
                    n_busy          = (n_cnt != '0) && !(nx_match && n_cnt < nx_len);
                    res.last_of_run = !n_busy;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_len    <= dss_pkg::LEN_W'(1);
            r_open_bytes  <= '0;
            r_close_len   <= dss_pkg::LEN_W'(1);
            r_close_bytes <= '0;
            r_in_valid    <= 1'b0;
            r_cnt         <= '0;
            r_link        <= 1'b0;
            r_ne          <= 1'b0;
            r_flush       <= 1'b0;
            r_busy        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dss_pkg::CFG_OPEN_LEN:    r_open_len    <= i_cfg_data[dss_pkg::LEN_W-1:0];
                    dss_pkg::CFG_OPEN_BYTES:  r_open_bytes  <= i_cfg_data;
                    dss_pkg::CFG_CLOSE_LEN:   r_close_len   <= i_cfg_data[dss_pkg::LEN_W-1:0];
                    dss_pkg::CFG_CLOSE_BYTES: r_close_bytes <= i_cfg_data;
                endcase
            end
            r_in_valid <= n_in_valid;
            r_cnt      <= n_cnt;
            r_link     <= n_link;
            r_ne       <= n_ne;
            r_flush    <= n_flush;
            r_busy     <= n_busy;
            // load a fresh result, else drop the one just taken
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_item <= i_in_item;
        end
        r_win <= n_win;
        if (res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

FILE: sim/delimited_segment_splitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_segment_splitter_tb: self-checking bench for the segment splitter
// Feeds byte streams and end-of-input marks through the splitter, predicts the
// text/link segment items in a behavioral model of its own and compares every
// output item field by field, with random idling, stalls and back-pressure.
// ----------------------------------------------------------------------------
module delimited_segment_splitter_tb;

    localparam int MAX_DELIM      = dss_pkg::MAX_DELIM_DEF;
    localparam int TAIL_CYCLES    = 2 * MAX_DELIM + 4;
    localparam int PHASE_ITEMS    = 75;
    localparam int WATCHDOG_LIMIT = 2000;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT connections
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                           i_cfg_we   = 1'b0;
    logic [dss_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [dss_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    dss_pkg::t_in_item  i_in_item  = '0;

    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    dss_pkg::t_out_item o_out_item;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    delimited_segment_splitter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    bit idle_on      = 1'b1;   // random gaps on both channels
    int hold_off_len = 0;      // long receiver hold-off, consumed by the receiver
    int fail_count   = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int reg_writes   = 0;

    // byte alphabet of the current random phase, shared by delimiters and data
    logic [7:0] alpha0, alpha1;

    // ------------------------------------------------------------------------
    // Splitter model: register copies and stream state
    // ------------------------------------------------------------------------
    logic [3:0]  open_len    = 4'd1;
    logic [63:0] open_bytes  = '0;
    logic [3:0]  close_len   = 4'd1;
    logic [63:0] close_bytes = '0;

    bit         link_mode    = 1'b0;
    logic [7:0] win [MAX_DELIM];
    int         win_count    = 0;
    bit         seg_has_data = 1'b0;

    dss_pkg::t_out_item segment_items_due [$];

    // Clamp a raw length register to the range the window supports.
    function automatic int delim_len(logic [3:0] raw);
        if (raw == 4'd0)
            return 1;
        if (int'(raw) > MAX_DELIM)
            return MAX_DELIM;
        return int'(raw);
    endfunction

    function automatic void shift_window(int k);
        if (k >= win_count) begin
            win_count = 0;
        end else begin
            for (int i = 0; i + k < win_count; i++)
                win[i] = win[i + k];
            win_count -= k;
        end
    endfunction

    function automatic void owe_item(logic [1:0] kind, logic [7:0] value, logic seg);
        dss_pkg::t_out_item r;
        r.out_kind     = kind;
        r.out_byte     = value;
        r.segment_type = seg;
        r.last_of_run  = 1'b0;
        segment_items_due.push_back(r);
    endfunction

    // Advance the model by one accepted input item and queue what it emits.
    function automatic void split_item(dss_pkg::t_in_item it);
        int          first;
        int          len;
        int          cmp;
        bit          hit;
        bit          stop;
        logic        seg;
        logic [63:0] pat;
        first = segment_items_due.size();
        stop  = 1'b0;
        if (it.req_type == dss_pkg::REQ_DATA) begin
            if (win_count < MAX_DELIM) begin
                win[win_count] = it.in_byte;
                win_count++;
            end
            // rescan the window against the delimiter of the current mode
            while (win_count > 0 && !stop) begin
                pat = link_mode ? close_bytes : open_bytes;
                len = delim_len(link_mode ? close_len : open_len);
                cmp = (win_count < len) ? win_count : len;
                seg = link_mode ? dss_pkg::SEG_LINK : dss_pkg::SEG_TEXT;
                hit = 1'b1;
                for (int i = 0; i < cmp; i++)
                    if (win[i] != pat[8*i +: 8])
                        hit = 1'b0;
                if (hit && win_count >= len) begin
                    owe_item(dss_pkg::KIND_SEG_END, 8'h00, seg);
                    shift_window(len);
                    link_mode    = !link_mode;
                    seg_has_data = 1'b0;
                end else if (hit) begin
                    stop = 1'b1;   // still a prefix: hold the bytes
                end else begin
                    owe_item(dss_pkg::KIND_DATA, win[0], seg);
                    seg_has_data = 1'b1;
                    shift_window(1);
                end
            end
        end else begin
            // end of input: flush, then close the text or flag the open link
            seg = link_mode ? dss_pkg::SEG_LINK : dss_pkg::SEG_TEXT;
            for (int i = 0; i < win_count; i++) begin
                owe_item(dss_pkg::KIND_DATA, win[i], seg);
                seg_has_data = 1'b1;
            end
            win_count = 0;
            if (link_mode)
                owe_item(dss_pkg::KIND_ERROR, 8'h00, dss_pkg::SEG_LINK);
            else if (seg_has_data)
                owe_item(dss_pkg::KIND_SEG_END, 8'h00, dss_pkg::SEG_TEXT);
            link_mode    = 1'b0;
            seg_has_data = 1'b0;
        end
        if (segment_items_due.size() > first)
            segment_items_due[segment_items_due.size() - 1].last_of_run = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Leaves valid high after acceptance; the next call or drain_block decides
    // whether it drops, so valid never toggles twice within one step.
    task automatic send_item(logic req, logic [7:0] value);
        int                gap;
        dss_pkg::t_in_item it;
        it.req_type = req;
        it.in_byte  = value;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!(i_in_valid === 1'b1 && o_in_stall === 1'b0));
        split_item(it);
        items_sent++;
    endtask

    // Send the first n bytes of the opening or closing delimiter.
    task automatic send_delim(bit closing, int n);
        logic [63:0] pat;
        pat = closing ? close_bytes : open_bytes;
        for (int i = 0; i < n; i++)
            send_item(dss_pkg::REQ_DATA, pat[8*i +: 8]);
    endtask

    // Stop offering, wait for every owed item, then let held work settle.
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (segment_items_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [dss_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            dss_pkg::CFG_OPEN_LEN:    open_len    = value[3:0];
            dss_pkg::CFG_OPEN_BYTES:  open_bytes  = value;
            dss_pkg::CFG_CLOSE_LEN:   close_len   = value[3:0];
            dss_pkg::CFG_CLOSE_BYTES: close_bytes = value;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_delims(logic [3:0] olen, logic [63:0] obytes,
                              logic [3:0] clen, logic [63:0] cbytes);
        drain_block();
        write_reg(dss_pkg::CFG_OPEN_LEN, {60'd0, olen});
        write_reg(dss_pkg::CFG_OPEN_BYTES, obytes);
        write_reg(dss_pkg::CFG_CLOSE_LEN, {60'd0, clen});
        write_reg(dss_pkg::CFG_CLOSE_BYTES, cbytes);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stall per item, plus an optional long hold-off
    // ------------------------------------------------------------------------
    initial begin : receiver
        int wait_n;
        forever begin
            if (hold_off_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_off_len) @(posedge i_clk);
                hold_off_len = 0;
            end
            wait_n = idle_on ? $urandom_range(0, 4) : 0;
            if (wait_n > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_stall === 1'b0));
        end
    end

    // Compare each accepted output item against the oldest owed one.
    always @(posedge i_clk) begin : result_check
        dss_pkg::t_out_item want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (segment_items_due.size() == 0) begin
                $error("unexpected item: out_kind %0d out_byte %h segment_type %0d",
                       o_out_item.out_kind, o_out_item.out_byte, o_out_item.segment_type);
                fail_count++;
            end else begin
                want = segment_items_due.pop_front();
                results_seen++;
                if (o_out_item.out_kind !== want.out_kind) begin
                    $error("out_kind: expected %0d, actual %0d",
                           want.out_kind, o_out_item.out_kind);
                    fail_count++;
                end
                if (o_out_item.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, actual %h",
                           want.out_byte, o_out_item.out_byte);
                    fail_count++;
                end
                if (o_out_item.segment_type !== want.segment_type) begin
                    $error("segment_type: expected %0d, actual %0d",
                           want.segment_type, o_out_item.segment_type);
                    fail_count++;
                end
                if (o_out_item.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, actual %0d",
                           want.last_of_run, o_out_item.last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // End the run if neither channel moves an item for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no item moved for %0d cycles, %0d items still owed",
                 WATCHDOG_LIMIT, segment_items_due.size());
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset delimiters are a single zero byte each.
    task automatic test_reset_defaults();
        send_item(dss_pkg::REQ_DATA, 8'h41);
        send_item(dss_pkg::REQ_DATA, 8'h00);   // opens a link
        send_item(dss_pkg::REQ_DATA, 8'hFF);
        send_item(dss_pkg::REQ_END, 8'hA5);    // link never closed: error, byte ignored
        send_item(dss_pkg::REQ_END, 8'h5A);    // empty final text: nothing emitted
    endtask

    // Two-byte delimiters: partial match released, empty segments, flush.
    task automatic test_two_byte_delims();
        set_delims(4'd2, 64'h5B5B, 4'd2, 64'h5D5D);
        send_item(dss_pkg::REQ_DATA, 8'h5B);   // prefix of the opener...
        send_item(dss_pkg::REQ_DATA, 8'h61);   // ...broken: both bytes go out as text
        send_delim(1'b0, 2);
        send_delim(1'b1, 2);                   // empty link segment
        send_delim(1'b0, 2);                   // empty text segment
        send_item(dss_pkg::REQ_DATA, 8'h5D);   // held as a closer prefix
        send_item(dss_pkg::REQ_END, 8'($urandom_range(0, 255)));
    endtask

    // Longest opener of all-ones bytes; closer length 0 acts as one byte.
    task automatic test_longest_delims();
        set_delims(4'd8, '1, 4'd0, 64'h0);
        send_delim(1'b0, 8);
        send_item(dss_pkg::REQ_END, 8'($urandom_range(0, 255)));
    endtask

    // Shorten the opener while three of its bytes sit in the window.
    task automatic test_midstream_config();
        send_delim(1'b0, 3);
        drain_block();
        write_reg(dss_pkg::CFG_OPEN_LEN, 64'd2);
        send_item(dss_pkg::REQ_DATA, 8'hFF);   // front two bytes match the new opener
        send_item(dss_pkg::REQ_DATA, 8'h00);   // closer
        send_item(dss_pkg::REQ_DATA, 8'h42);
        send_item(dss_pkg::REQ_END, 8'h00);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return alpha0;
        if (r < 5)
            return alpha1;
        return 8'($urandom);
    endfunction

    function automatic logic [63:0] build_delim();
        logic [63:0] d;
        for (int i = 0; i < 8; i++)
            d[8*i +: 8] = pick_byte();
        return d;
    endfunction

    // Mostly well-formed text/link streams drawn from a small alphabet so
    // that partial and overlapping matches are common; some noise on top.
    task automatic test_random_phase(logic [3:0] olen, logic [3:0] clen,
                                     bit idle, int hold, bit pause);
        int  sent;
        int  pick;
        int  n;
        bit  link_guess;
        bit  paused;
        logic [63:0] ob;
        logic [63:0] cb;
        alpha0 = 8'($urandom);
        alpha1 = 8'($urandom);
        ob = build_delim();
        cb = build_delim();
        set_delims(olen, ob, clen, cb);
        idle_on      = idle;
        hold_off_len = hold;
        sent         = 0;
        link_guess   = 1'b0;
        paused       = 1'b0;
        while (sent < PHASE_ITEMS) begin
            if (pause && !paused && sent >= PHASE_ITEMS / 2) begin
                drain_block();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            n    = delim_len(link_guess ? clen : olen);
            if (pick < 50) begin
                send_item(dss_pkg::REQ_DATA, pick_byte());
                sent++;
            end else if (pick < 80) begin
                send_delim(link_guess, n);
                sent += n;
                link_guess = !link_guess;
            end else if (pick < 88) begin
                if (n > 1) begin
                    n = $urandom_range(1, n - 1);
                    send_delim(link_guess, n);
                    sent += n;
                end
            end else if (pick < 94) begin
                send_item(dss_pkg::REQ_END, 8'($urandom));
                sent++;
                link_guess = 1'b0;
            end else begin
                // wrong delimiter for the guessed mode
                n = delim_len(link_guess ? olen : clen);
                send_delim(!link_guess, n);
                sent += n;
            end
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin : main
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_two_byte_delims();
        test_longest_delims();
        test_midstream_config();

        test_random_phase(4'd1, 4'd1, 1'b1, 0, 1'b0);
        test_random_phase(4'($urandom_range(2, 7)), 4'($urandom_range(2, 7)),
                          1'b1, 120, 1'b0);
        test_random_phase(4'd8, 4'd8, 1'b1, 0, 1'b1);
        test_random_phase(4'd0, 4'd15, 1'b1, 0, 1'b0);
        test_random_phase(4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)),
                          1'b0, 0, 1'b0);
        test_random_phase(4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)),
                          1'b1, 0, 1'b0);

        drain_block();
        $display("Run covered %0d input items, %0d output items checked, %0d register writes",
                 items_sent, results_seen, reg_writes);
        $display("Delimiter lengths 0 to 15, overlapping patterns, stalls and hold-off exercised");
        if (fail_count == 0 && segment_items_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
